>>> hw/rtl/bspi_pkg.sv
// ============================================================================
// bspi_pkg: shared types and codes of the BGR stream palette indexer
// Word layouts of both channels, status and register codes, palette
// segment geometry and the match/write records between top and palette.
// ============================================================================
package bspi_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;

    // The palette chain is cut into segments; a hit ripples only through the cells of its own segment.
    localparam int SEG_SIZE  = 8;
    localparam int SEG_IDX_W = 3;

    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_END  = 1'b1;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_TRUNCATED = 3'd1;
    localparam logic [2:0] STATUS_MISMATCH  = 3'd2;
    localparam logic [2:0] STATUS_FULL      = 3'd3;
    localparam logic [2:0] STATUS_SURPLUS   = 3'd4;

    localparam logic [1:0] REG_ROW_WIDTH       = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT       = 2'd1;
    localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd2;

    localparam logic [2:0] BPP_THREE = 3'd3;
    localparam logic [2:0] BPP_FOUR  = 3'd4;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } byte_word_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [31:0] pixel_address;
        logic [7:0]  color_index;
        logic        is_new_color;
        logic [31:0] color_value;
    } result_word_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] index;
    } match_t;

    typedef struct packed {
        logic        en;
        logic [31:0] color;
    } pal_write_t;

endpackage

>>> hw/rtl/bspi_cell.sv
// ============================================================================
// bspi_cell: one palette cell
// Holds one palette entry, compares it with the query color and passes the
// running hit flag and local index on to its neighbor in the segment.
// ============================================================================
module bspi_cell
    import bspi_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 9
)
(
    input  logic                 clk,
    input  pal_write_t           wr,
    input  logic [31:0]          query,
    input  logic [CNT_W-1:0]     entry_count,
    input  logic                 hit_in,
    input  logic [SEG_IDX_W-1:0] idx_in,
    output logic                 hit_out,
    output logic [SEG_IDX_W-1:0] idx_out
);

    localparam logic [CNT_W-1:0]     MY_SLOT  = CNT_W'(CELL_IDX);
    localparam logic [SEG_IDX_W-1:0] MY_LOCAL = SEG_IDX_W'(CELL_IDX % SEG_SIZE);

    logic [31:0] entry_reg;
    logic [31:0] entry_next;
    logic        hit;

    // A new color always lands in the slot equal to the current entry count.
    always_comb
    begin
        entry_next = entry_reg;
        if (wr.en && (entry_count == MY_SLOT))
        begin
            entry_next = wr.color;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // Slots at or above the entry count were never filled and must not match.
    assign hit     = (entry_reg == query) && (MY_SLOT < entry_count);
    assign hit_out = hit_in | hit;
    assign idx_out = idx_in | (hit ? MY_LOCAL : '0);

endmodule

>>> hw/rtl/bspi_palette.sv
// ============================================================================
// bspi_palette: first-seen color palette
// A row of cells split into segments; each segment hands its hit along the
// chain, a register stage captures every segment, a second stage merges them.
// ============================================================================
module bspi_palette
    import bspi_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
    parameter int CNT_W         = $clog2(PALETTE_DEPTH + 1)
)
(
    input  logic             clk,
    input  pal_write_t       wr,
    input  logic [31:0]      query,
    input  logic [CNT_W-1:0] entry_count,
    output match_t           match
);

    localparam int NUM_SEGS = (PALETTE_DEPTH + SEG_SIZE - 1) / SEG_SIZE;

    logic                 hin  [PALETTE_DEPTH];
    logic [SEG_IDX_W-1:0] iin  [PALETTE_DEPTH];
    logic                 hout [PALETTE_DEPTH];
    logic [SEG_IDX_W-1:0] iout [PALETTE_DEPTH];

    logic                 seg_hit_reg [NUM_SEGS];
    logic [SEG_IDX_W-1:0] seg_idx_reg [NUM_SEGS];

    match_t match_reg;
    match_t match_next;

    for (genvar i = 0; i < PALETTE_DEPTH; i++)
    begin : g_cell
        if (i % SEG_SIZE == 0)
        begin : g_head
            assign hin[i] = 1'b0;
            assign iin[i] = '0;
        end
        else
        begin : g_body
            assign hin[i] = hout[i-1];
            assign iin[i] = iout[i-1];
        end

        bspi_cell #(
            .CELL_IDX (i),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk         (clk),
            .wr          (wr),
            .query       (query),
            .entry_count (entry_count),
            .hit_in      (hin[i]),
            .idx_in      (iin[i]),
            .hit_out     (hout[i]),
            .idx_out     (iout[i])
        );
    end

    for (genvar s = 0; s < NUM_SEGS; s++)
    begin : g_seg
        localparam int TAIL = ((s + 1) * SEG_SIZE < PALETTE_DEPTH) ?
                              (s + 1) * SEG_SIZE - 1 : PALETTE_DEPTH - 1;

        always_ff @(posedge clk)
        begin
            seg_hit_reg[s] <= hout[TAIL];
            seg_idx_reg[s] <= iout[TAIL];
        end
    end

    // The palette holds no duplicates, so at most one segment reports a hit.
    always_comb
    begin
        match_next = '0;
        for (int s = 0; s < NUM_SEGS; s++)
        begin
            if (seg_hit_reg[s])
            begin
                match_next.hit   = 1'b1;
                match_next.index = match_next.index | 8'(s * SEG_SIZE)
                                   | 8'(seg_idx_reg[s]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
    end

    assign match = match_reg;

endmodule

>>> hw/rtl/bgr_stream_palette_indexer.sv
// ============================================================================
// bgr_stream_palette_indexer: palette indexing of a bottom-up BGR(A) stream
// Assembles pixels from bytes, looks each one up in a first-seen palette,
// and reports its top-down address and palette index.
// ============================================================================
//
//  Channel   Signals                           Word
//  bytes     byte_valid byte_ready byte_data   byte_word_t: mode, data_byte
//  results   res_valid  res_ready  res_data    result_word_t: pixel or report
//  config    cfg_we cfg_index cfg_data         width, height, bytes per pixel
//
// A completing byte starts a lookup through the steps compare and segment chain,
// segment merge and update; no further byte is taken until the update is done.
// An end word is reported and clears the stream state. No clearing pass after reset.
// A stalled result holds the block in its last step until the word is taken.
//
module bgr_stream_palette_indexer
    import bspi_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    output logic         byte_ready,
    input  byte_word_t   byte_data,
    output logic         res_valid,
    input  logic         res_ready,
    output result_word_t res_data,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PALETTE_DEPTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CMP  = 3'd1;
    localparam logic [2:0] ST_GRP  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_END  = 3'd4;

    logic [15:0] row_width_reg, row_width_next;
    logic [15:0] row_count_reg, row_count_next;
    logic [2:0]  bpp_reg, bpp_next;

    logic [2:0]       state_reg, state_next;
    logic [23:0]      partial_reg, partial_next;
    logic [1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      col_reg, col_next;
    logic [16:0]      rows_reg, rows_next;
    logic [2:0]       err_reg, err_next;
    logic             res_valid_reg, res_valid_next;

    logic [31:0]  query_reg, query_next;
    logic         surplus_reg, surplus_next;
    logic [31:0]  product_reg, product_next;
    logic [31:0]  addr_reg, addr_next;
    result_word_t res_reg, res_next;

    logic        slot_free;
    logic [15:0] width_eff;
    logic [16:0] rows_left;
    logic [15:0] col_inc;
    logic [1:0]  last_pos;
    match_t      match;
    pal_write_t  pal_wr;

    assign slot_free  = !res_valid_reg || res_ready;
    assign width_eff  = (row_width_reg == 16'd0) ? 16'd1 : row_width_reg;
    assign rows_left  = {1'b0, row_count_reg} - 17'd1 - rows_reg;
    assign col_inc    = col_reg + 16'd1;
    assign last_pos   = (bpp_reg == BPP_FOUR) ? 2'd3 : 2'd2;
    assign byte_ready = (state_reg == ST_IDLE);

    // Configuration registers.
    always_comb
    begin
        row_width_next = row_width_reg;
        row_count_next = row_count_reg;
        bpp_next       = bpp_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW_WIDTH:       row_width_next = cfg_data;
                REG_ROW_COUNT:       row_count_next = cfg_data;
                REG_BYTES_PER_PIXEL: bpp_next       = cfg_data[2:0];
                default:             ;
            endcase
        end
    end

    // Datapath registers without reset.
    always_comb
    begin
        query_next   = query_reg;
        surplus_next = surplus_reg;
        product_next = {16'd0, rows_left[15:0]} * {16'd0, width_eff};
        addr_next    = product_reg + {16'd0, col_reg};
        if (byte_valid && byte_ready && (byte_data.mode == MODE_DATA)
            && (pos_reg >= last_pos))
        begin
            if (pos_reg == 2'd3)
            begin
                query_next = {partial_reg[23:16], partial_reg[15:8],
                              partial_reg[7:0], byte_data.data_byte};
            end
            else
            begin
                query_next = {byte_data.data_byte, partial_reg[15:8],
                              partial_reg[7:0], 8'd0};
            end
            surplus_next = (rows_reg >= {1'b0, row_count_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg   <= query_next;
        surplus_reg <= surplus_next;
        product_reg <= product_next;
        addr_reg    <= addr_next;
        res_reg     <= res_next;
    end

    // Control: byte assembly, lookup sequence, counters and result register.
    always_comb
    begin
        state_next     = state_reg;
        partial_next   = partial_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        col_next       = col_reg;
        rows_next      = rows_reg;
        err_next       = err_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        pal_wr.en      = 1'b0;
        pal_wr.color   = query_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (byte_valid)
                begin
                    if (byte_data.mode == MODE_END)
                    begin
                        state_next = ST_END;
                    end
                    else if (pos_reg >= last_pos)
                    begin
                        partial_next = '0;
                        pos_next     = 2'd0;
                        state_next   = ST_CMP;
                    end
                    else
                    begin
                        partial_next = 24'(partial_reg
                                       | ({16'd0, byte_data.data_byte} << {pos_reg, 3'd0}));
                        pos_next     = pos_reg + 2'd1;
                    end
                end
            end

            ST_CMP:
            begin
                state_next = ST_GRP;
            end

            ST_GRP:
            begin
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                if (slot_free)
                begin
                    res_next.kind          = KIND_PIXEL;
                    res_next.pixel_address = 32'd0;
                    res_next.color_index   = 8'd0;
                    res_next.is_new_color  = 1'b0;
                    res_next.color_value   = query_reg;
                    if (surplus_reg)
                    begin
                        if (err_reg == STATUS_OK)
                        begin
                            err_next = STATUS_SURPLUS;
                        end
                    end
                    else
                    begin
                        res_next.pixel_address = addr_reg;
                        if (match.hit)
                        begin
                            res_next.color_index = match.index;
                        end
                        else if (count_reg < DEPTH_CNT)
                        begin
                            pal_wr.en             = 1'b1;
                            res_next.color_index  = 8'(count_reg);
                            res_next.is_new_color = 1'b1;
                            count_next            = count_reg + 1'b1;
                        end
                        else if (err_reg == STATUS_OK)
                        begin
                            err_next = STATUS_FULL;
                        end
                        if (col_inc >= width_eff)
                        begin
                            col_next  = 16'd0;
                            rows_next = rows_reg + 17'd1;
                        end
                        else
                        begin
                            col_next = col_inc;
                        end
                    end
                    res_next.status = err_next;
                    res_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_END:
            begin
                if (slot_free)
                begin
                    res_next = '0;
                    res_next.kind = KIND_REPORT;
                    if (pos_reg != 2'd0)
                    begin
                        res_next.status = STATUS_TRUNCATED;
                    end
                    else if ((rows_reg != {1'b0, row_count_reg}) || (col_reg != 16'd0))
                    begin
                        res_next.status = STATUS_MISMATCH;
                    end
                    else
                    begin
                        res_next.status = err_reg;
                    end
                    res_valid_next = 1'b1;
                    partial_next   = '0;
                    pos_next       = 2'd0;
                    count_next     = '0;
                    col_next       = 16'd0;
                    rows_next      = 17'd0;
                    err_next       = STATUS_OK;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= 16'd1;
            row_count_reg <= 16'd1;
            bpp_reg       <= 3'd3;
            state_reg     <= ST_IDLE;
            partial_reg   <= '0;
            pos_reg       <= 2'd0;
            count_reg     <= '0;
            col_reg       <= 16'd0;
            rows_reg      <= 17'd0;
            err_reg       <= STATUS_OK;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            row_width_reg <= row_width_next;
            row_count_reg <= row_count_next;
            bpp_reg       <= bpp_next;
            state_reg     <= state_next;
            partial_reg   <= partial_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            col_reg       <= col_next;
            rows_reg      <= rows_next;
            err_reg       <= err_next;
            res_valid_reg <= res_valid_next;
        end
    end

    bspi_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .CNT_W         (CNT_W)
    ) u_palette (
        .clk         (clk),
        .wr          (pal_wr),
        .query       (query_reg),
        .entry_count (count_reg),
        .match       (match)
    );

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule
